FILE: design/pqms_pkg.sv
// ----------------------------------------------------------------------------
// Priority queue with mask select: shared definitions
// Field widths, operation and status codes, descriptor and term types.
// ----------------------------------------------------------------------------
package pqms_pkg;

   localparam int QueueDepthDefault = 16;
   localparam int MaxTermsDefault   = 8;

   typedef enum logic [2:0] {
      MODE_ENQUEUE = 3'd0,
      MODE_LOAD    = 3'd1,
      MODE_CLEAR   = 3'd2,
      MODE_PEEK    = 3'd3,
      MODE_REMOVE  = 3'd4,
      MODE_RSVD5   = 3'd5,
      MODE_RSVD6   = 3'd6,
      MODE_RSVD7   = 3'd7
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NO_MATCH  = 2'd1,
      ST_Q_FULL    = 2'd2,
      ST_MASK_FULL = 2'd3
   } status_type;

   localparam logic [2:0] KIND_MSGID    = 3'd0;
   localparam logic [2:0] KIND_MSGTYPE  = 3'd1;
   localparam logic [2:0] KIND_PRIORITY = 3'd2;
   localparam logic [2:0] KIND_DATATYPE = 3'd3;
   localparam logic [2:0] KIND_PROTECT  = 3'd4;
   localparam logic [2:0] KIND_SENDER   = 3'd5;

   localparam logic [2:0] REL_NONE = 3'd0;
   localparam logic [2:0] REL_EQ   = 3'd1;
   localparam logic [2:0] REL_NE   = 3'd2;
   localparam logic [2:0] REL_LT   = 3'd3;
   localparam logic [2:0] REL_LE   = 3'd4;
   localparam logic [2:0] REL_GT   = 3'd5;
   localparam logic [2:0] REL_GE   = 3'd6;

   typedef struct packed {
      logic [31:0] prio;
      logic [3:0]  mtype;
      logic [3:0]  plevel;
      logic [63:0] idh;
      logic [63:0] idl;
      logic [63:0] dth;
      logic [63:0] dtl;
      logic [63:0] sdh;
      logic [63:0] sdl;
   } desc_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [2:0]  rel;
      logic [63:0] vh;
      logic [63:0] vl;
   } term_type;

   typedef struct packed {
      logic [2:0]  mode;
      desc_type    desc;
      logic [2:0]  term_kind;
      logic [2:0]  term_relation;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [4:0]  entry_count;
      logic [3:0]  position;
      desc_type    desc;
   } rsp_type;

   // Control that the sequencer broadcasts to every cell of the row.
   typedef struct packed {
      logic     insert;   // shift right from insert point, load new entry
      logic     remove;   // shift left from the matched entry
      logic     check;    // evaluate one mask term in every cell
      logic     clear;    // start a new search: all cells match
   } cell_ctl_type;

   function automatic logic term_holds(term_type t, desc_type e);
      logic same_id;
      logic same_dt;
      logic same_sd;
      logic [31:0] v;
      logic ok;
      same_id = (t.vh == e.idh) && (t.vl == e.idl);
      same_dt = (t.vh == e.dth) && (t.vl == e.dtl);
      same_sd = (t.vh == e.sdh) && (t.vl == e.sdl);
      v = t.vl[31:0];
      ok = 1'b1;
      if (t.rel != REL_NONE && t.rel <= REL_GE) begin
         unique case (t.kind)
            KIND_MSGID:    ok = (t.rel == REL_EQ) ? same_id :
                                (t.rel == REL_NE) ? !same_id : 1'b1;
            KIND_DATATYPE: ok = (t.rel == REL_EQ) ? same_dt :
                                (t.rel == REL_NE) ? !same_dt : 1'b1;
            KIND_SENDER:   ok = (t.rel == REL_EQ) ? same_sd :
                                (t.rel == REL_NE) ? !same_sd : 1'b1;
            KIND_MSGTYPE:  ok = (t.rel == REL_EQ) ? (t.vl[3:0] == e.mtype) :
                                (t.rel == REL_NE) ? (t.vl[3:0] != e.mtype) : 1'b1;
            KIND_PROTECT:  ok = (t.rel == REL_EQ) ? (t.vl[3:0] == e.plevel) :
                                (t.rel == REL_NE) ? (t.vl[3:0] != e.plevel) : 1'b1;
            KIND_PRIORITY: begin
               unique case (t.rel)
                  REL_EQ:  ok = e.prio == v;
                  REL_NE:  ok = e.prio != v;
                  REL_LT:  ok = e.prio < v;
                  REL_LE:  ok = e.prio <= v;
                  REL_GT:  ok = e.prio > v;
                  default: ok = e.prio >= v;
               endcase
            end
            default:       ok = 1'b1;
         endcase
      end
      return ok;
   endfunction

endpackage

FILE: design/pqms_if.sv
// ----------------------------------------------------------------------------
// Valid/ready channel
// Carries one payload of a generic type between a source and a sink.
// ----------------------------------------------------------------------------
interface pqms_if #(parameter type payload_type = logic) (input logic clock);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

FILE: design/pqms_cell.sv
// ----------------------------------------------------------------------------
// Queue cell
// Holds one descriptor, compares its priority with an arriving entry,
// evaluates broadcast mask terms and shifts to either neighbor.
// ----------------------------------------------------------------------------
module pqms_cell (
   input  logic                  clock,
   input  pqms_pkg::cell_ctl_type ctl,
   input  pqms_pkg::desc_type    new_desc,
   input  pqms_pkg::term_type    term,
   input  logic                  occupied,     // slot index below entry count
   input  logic                  left_goes,    // left neighbor is at or past insert point
   input  pqms_pkg::desc_type    left_desc,
   input  pqms_pkg::desc_type    right_desc,
   input  logic                  left_removed, // a left neighbor or this cell is removed
   output logic                  goes,         // this cell takes part in the right shift
   output logic                  hit,
   output pqms_pkg::desc_type    desc
);
   pqms_pkg::desc_type desc_ff, desc_in;
   logic hit_ff, hit_in;

   // Goes right if left neighbor goes, cell is empty, or priority exceeds the new one.
   assign goes = left_goes || (occupied && (new_desc.prio < desc_ff.prio)) || !occupied;

   always_comb begin
      desc_in = desc_ff;
      hit_in  = hit_ff;
      if (ctl.insert) begin
         if (left_goes) begin
            desc_in = left_desc;
         end else if (goes) begin
            desc_in = new_desc;
         end
      end
      if (ctl.remove && left_removed) begin
         desc_in = right_desc;
      end
      if (ctl.clear) begin
         hit_in = 1'b1;
      end else if (ctl.check) begin
         hit_in = hit_ff && pqms_pkg::term_holds(term, desc_ff);
      end
   end

   always_ff @(posedge clock) begin
      desc_ff <= desc_in;
      hit_ff  <= hit_in;
   end

   assign hit  = hit_ff;
   assign desc = desc_ff;
endmodule

FILE: design/priority_queue_with_mask_select_core.sv
// ----------------------------------------------------------------------------
// Priority queue with mask select
// Enqueue, term load and clear go from idle through the check state to the
// response; a search evaluates one loaded term a cycle in all cells at
// once, then picks the match. One operation is in flight at a time.
// Reset empties the queue and the mask set; stored data is not cleared.
// ----------------------------------------------------------------------------
module priority_queue_with_mask_select_core #(
   parameter int QUEUE_DEPTH = pqms_pkg::QueueDepthDefault,
   parameter int MAX_TERMS   = pqms_pkg::MaxTermsDefault
) (
   input logic clock,
   input logic reset,
   pqms_if.sink   req,
   pqms_if.source rsp
);
   localparam int QW = $clog2(QUEUE_DEPTH + 1);
   localparam int QI = $clog2(QUEUE_DEPTH);
   localparam int TW = $clog2(MAX_TERMS + 1);
   localparam int TI = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_CHECK = 4'b0010,
      S_PICK  = 4'b0100,
      S_RESP  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   pqms_pkg::req_type req_ff, req_in;
   pqms_pkg::rsp_type rsp_ff, rsp_in;
   logic [QW-1:0] count_ff, count_in;
   logic [TW-1:0] mtot_ff, mtot_in;
   logic [TW-1:0] tidx_ff, tidx_in;
   logic [QI-1:0] pick_ff, pick_in;
   pqms_pkg::term_type terms_ff [MAX_TERMS];
   pqms_pkg::term_type term_new;
   logic term_we;

   pqms_pkg::cell_ctl_type ctl;
   pqms_pkg::desc_type cdesc [QUEUE_DEPTH];
   logic cgoes [QUEUE_DEPTH];
   logic chit  [QUEUE_DEPTH];
   logic crem  [QUEUE_DEPTH];
   pqms_pkg::term_type cur_term;
   logic [QI-1:0] ins_pos, hit_pos;
   logic any_hit;

   assign cur_term = terms_ff[tidx_ff[TI-1:0]];

   genvar g;
   generate
      for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
         logic lg, lr;
         pqms_pkg::desc_type ld, rd;
         if (g == 0) begin : g_first
            assign lg = 1'b0;
            assign ld = req_ff.desc;
            assign lr = (pick_ff == QI'(0));
         end else begin : g_rest
            assign lg = cgoes[g-1];
            assign ld = cdesc[g-1];
            assign lr = crem[g-1] || (pick_ff == QI'(g));
         end
         if (g == QUEUE_DEPTH - 1) begin : g_last
            assign rd = cdesc[g];
         end else begin : g_mid
            assign rd = cdesc[g+1];
         end
         assign crem[g] = lr;
         pqms_cell u_cell (
            .clock       (clock),
            .ctl         (ctl),
            .new_desc    (req_ff.desc),
            .term        (cur_term),
            .occupied    (QW'(g) < count_ff),
            .left_goes   (lg),
            .left_desc   (ld),
            .right_desc  (rd),
            .left_removed(lr),
            .goes        (cgoes[g]),
            .hit         (chit[g]),
            .desc        (cdesc[g])
         );
      end
   endgenerate

   // First cell that goes right is the insert point; first hit is the match.
   always_comb begin
      ins_pos = '0;
      hit_pos = '0;
      any_hit = 1'b0;
      for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
         if (cgoes[i]) ins_pos = QI'(i);
         if (chit[i] && (QW'(i) < count_ff)) begin
            hit_pos = QI'(i);
            any_hit = 1'b1;
         end
      end
   end

   always_comb begin
      term_new.kind = req_ff.term_kind;
      term_new.rel  = req_ff.term_relation;
      term_new.vh   = req_ff.desc.idh;
      term_new.vl   = req_ff.desc.idl;
      if (req_ff.term_kind == pqms_pkg::KIND_PRIORITY) begin
         term_new.vh = '0;
         term_new.vl = {32'd0, req_ff.desc.prio};
      end else if (req_ff.term_kind == pqms_pkg::KIND_MSGTYPE) begin
         term_new.vh = '0;
         term_new.vl = {60'd0, req_ff.desc.mtype};
      end else if (req_ff.term_kind == pqms_pkg::KIND_PROTECT) begin
         term_new.vh = '0;
         term_new.vl = {60'd0, req_ff.desc.plevel};
      end
   end

   always_comb begin
      state_in = state_ff;
      req_in   = req_ff;
      rsp_in   = rsp_ff;
      count_in = count_ff;
      mtot_in  = mtot_ff;
      tidx_in  = tidx_ff;
      pick_in  = pick_ff;
      ctl      = '0;
      term_we  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            pick_in = QI'(QUEUE_DEPTH - 1);
            if (req.valid) begin
               req_in   = req.payload;
               tidx_in  = '0;
               ctl.clear = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            rsp_in = '0;
            unique case (pqms_pkg::mode_type'(req_ff.mode))
               pqms_pkg::MODE_ENQUEUE: begin
                  if (count_ff >= QW'(QUEUE_DEPTH)) begin
                     rsp_in.status = pqms_pkg::ST_Q_FULL;
                  end else begin
                     ctl.insert = 1'b1;
                     rsp_in.position = 4'(ins_pos);
                     count_in = count_ff + QW'(1);
                  end
                  state_in = S_RESP;
               end
               pqms_pkg::MODE_LOAD: begin
                  if (mtot_ff >= TW'(MAX_TERMS)) begin
                     rsp_in.status = pqms_pkg::ST_MASK_FULL;
                  end else begin
                     term_we = 1'b1;
                     mtot_in = mtot_ff + TW'(1);
                  end
                  state_in = S_RESP;
               end
               pqms_pkg::MODE_CLEAR: begin
                  mtot_in  = '0;
                  state_in = S_RESP;
               end
               pqms_pkg::MODE_PEEK, pqms_pkg::MODE_REMOVE: begin
                  if (tidx_ff < mtot_ff) begin
                     ctl.check = 1'b1;
                     tidx_in = tidx_ff + TW'(1);
                  end else begin
                     state_in = S_PICK;
                  end
               end
               default: state_in = S_RESP;
            endcase
         end
         S_PICK: begin
            rsp_in = '0;
            if (!any_hit) begin
               rsp_in.status = pqms_pkg::ST_NO_MATCH;
            end else begin
               rsp_in.position = 4'(hit_pos);
               rsp_in.desc     = cdesc[hit_pos];
               if (req_ff.mode == pqms_pkg::MODE_REMOVE) begin
                  pick_in  = hit_pos;
                  count_in = count_ff - QW'(1);
               end
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            // Removal shift happens once while the response is shown.
            if (pick_ff != QI'(QUEUE_DEPTH - 1) || req_ff.mode == pqms_pkg::MODE_REMOVE) begin
               ctl.remove = 1'b1;
               pick_in = QI'(QUEUE_DEPTH - 1);
            end
            if (rsp.ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      rsp_in.entry_count = 5'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         mtot_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         mtot_ff  <= mtot_in;
      end
      req_ff  <= req_in;
      rsp_ff  <= rsp_in;
      tidx_ff <= tidx_in;
      pick_ff <= pick_in;
      if (term_we) begin
         terms_ff[mtot_ff[TI-1:0]] <= term_new;
      end
   end

   assign req.ready   = (state_ff == S_IDLE);
   assign rsp.valid   = (state_ff == S_RESP);
   assign rsp.payload = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QW'(QUEUE_DEPTH))
      else $error("entry count above depth");
   a_mask_bound: assert property (@(posedge clock) disable iff (reset)
      mtot_ff <= TW'(MAX_TERMS))
      else $error("mask total above limit");
   a_one_op: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> !req.ready)
      else $error("second request taken while busy");
endmodule
